### hdl/differential_drive_odometry_macros.svh
// Assertion macros for the differential drive odometry block.
// Included by modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DDO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DDO_ASSERT(lbl, prop, msg)
`define DDO_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

### hdl/ddo_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the odometry block.
// No dependencies.
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_ITERS = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic [28:0] INV4PI = 29'd341782638;

    localparam logic [2:0] CFG_HALF_TRACK    = 3'd0;
    localparam logic [2:0] CFG_STEP_TIME     = 3'd1;
    localparam logic [2:0] CFG_START_X       = 3'd2;
    localparam logic [2:0] CFG_START_Y       = 3'd3;
    localparam logic [2:0] CFG_START_HEADING = 3'd4;

    typedef enum logic [2:0] {
        A_L, A_AD, A_PROD, A_H, A_DIST, A_RAD, A_U, A_W
    } t_asel;

    typedef enum logic [2:0] {
        B_ST, B_INV, B_AS, B_CH, B_SH, B_SP, B_NCP
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        DST_NONE, DST_DIST, DST_U, DST_W, DST_DXP, DST_DYP, DST_DXA, DST_DYA
    } t_dst;

    typedef struct packed {
        logic    latch_in;
        logic    cord_start;
        logic    cord_sel_phi;
        logic    cap_sc;
        logic    mul_en;
        t_asel   asel;
        t_bsel   bsel;
        t_acc_op acc_op;
        t_dst    dst;
        logic    div_start;
        logic    div_sel_rad;
        logic    cap_phi;
        logic    cap_rad;
        logic    head_upd;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic straight;
        logic cord_busy;
        logic div_busy;
    } t_sts;

    function automatic logic [31:0] atan_val(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680862;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### hdl/ddo_cordic.sv
// Iterative CORDIC sine/cosine of a 32-bit binary angle, one rotation per cycle.
// Depends on ddo_pkg for the gain and arctangent table.
`default_nettype none
module ddo_cordic import ddo_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_angle,
    output logic                    o_busy,
    output logic signed [31:0]      o_sin,
    output logic signed [31:0]      o_cos
);

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic signed [33:0] r_x, r_y, r_z;
    logic              r_flip;
    logic [31:0]       w_ang;
    logic              w_flip;
    logic signed [33:0] w_dx, w_dy, w_at, w_xo, w_yo;

    assign w_flip = (i_angle[31:30] == 2'b01) || (i_angle[31:30] == 2'b10);
    assign w_ang  = w_flip ? i_angle + 32'h8000_0000 : i_angle;
    assign w_dx   = r_y >>> r_cnt;
    assign w_dy   = r_x >>> r_cnt;
    assign w_at   = $signed({2'b00, atan_val(r_cnt)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(CORDIC_ITERS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= 34'($signed(w_ang));
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign w_xo = r_flip ? -r_x : r_x;
    assign w_yo = r_flip ? -r_y : r_y;

    always_comb begin
        if (w_xo > 34'(ONE_Q30)) begin
            o_cos = ONE_Q30;
        end else if (w_xo < -34'(ONE_Q30)) begin
            o_cos = -ONE_Q30;
        end else begin
            o_cos = w_xo[31:0];
        end
        if (w_yo > 34'(ONE_Q30)) begin
            o_sin = ONE_Q30;
        end else if (w_yo < -34'(ONE_Q30)) begin
            o_sin = -ONE_Q30;
        end else begin
            o_sin = w_yo[31:0];
        end
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

### hdl/ddo_div.sv
// Restoring unsigned divider, 48-bit dividend by 20-bit divisor, one quotient bit per cycle.
// Depends on nothing but the shared package import convention.
`default_nettype none
module ddo_div import ddo_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_dividend,
    input  wire logic [19:0] i_divisor,
    output logic             o_busy,
    output logic [47:0]      o_quot
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [47:0] r_q;
    logic [19:0] r_rem;
    logic [19:0] r_dvs;
    logic [20:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem, r_q[47]};
    assign w_ge = w_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[46:0], w_ge};
            r_rem <= w_ge ? 20'(w_sh - {1'b0, r_dvs}) : w_sh[19:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule
`default_nettype wire

### hdl/ddo_dp.sv
// Odometry datapath: configuration and pose registers, shared multiplier and accumulator,
// divider and CORDIC units, output register. Depends on ddo_pkg, ddo_cordic, ddo_div.
`default_nettype none
module ddo_dp import ddo_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic signed [15:0] i_left_speed,
    input  wire logic signed [15:0] i_right_speed,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic signed [31:0]      o_new_x,
    output logic signed [31:0]      o_new_y,
    output logic [15:0]             o_new_heading,
    output logic                    o_went_straight,
    output logic                    o_clipped
);

    logic [15:0]        r_half_track, r_step_time;
    logic signed [31:0] r_pose_x, r_pose_y;
    logic [15:0]        r_pose_h;

    logic signed [15:0] r_l, r_r;
    logic signed [31:0] r_sh, r_ch;
    logic signed [69:0] r_prod, r_acc;
    logic signed [34:0] r_dist, r_u, r_w, r_dx, r_dy;
    logic [31:0]        r_phi;
    logic signed [31:0] r_rad;
    logic               r_rclip;
    logic [15:0]        r_head;

    logic signed [16:0] w_d, w_s;
    logic [16:0]        w_ad, w_as;
    logic [15:0]        w_h;
    logic signed [34:0] w_a, w_b;
    logic signed [69:0] w_prod, w_rp30, w_ra30, w_rp16;
    logic signed [31:0] w_sin, w_cos;
    logic               w_cord_busy, w_div_busy;
    logic [31:0]        w_cord_ang;
    logic [63:0]        w_pn;
    logic [47:0]        w_dvd, w_quot;
    logic [19:0]        w_dvs;
    logic [31:0]        w_phi_q, w_phi_inc;
    logic               w_rsat;
    logic [30:0]        w_rmag;
    logic signed [35:0] w_nx, w_ny;
    logic               w_cx, w_cy;
    logic signed [31:0] w_nxs, w_nys;

    assign w_d  = 17'(r_l) - 17'(r_r);
    assign w_s  = 17'(r_l) + 17'(r_r);
    assign w_ad = w_d[16] ? 17'(-w_d) : 17'(w_d);
    assign w_as = w_s[16] ? 17'(-w_s) : 17'(w_s);
    assign w_h  = (r_half_track == 16'd0) ? 16'd1 : r_half_track;

    always_comb begin
        case (i_cmd.asel)
            A_L:     w_a = 35'(r_l);
            A_AD:    w_a = $signed({18'b0, w_ad});
            A_PROD:  w_a = r_prod[34:0];
            A_H:     w_a = $signed({19'b0, w_h});
            A_DIST:  w_a = r_dist;
            A_RAD:   w_a = 35'(r_rad);
            A_U:     w_a = r_u;
            A_W:     w_a = r_w;
            default: w_a = '0;
        endcase
        case (i_cmd.bsel)
            B_ST:    w_b = $signed({19'b0, r_step_time});
            B_INV:   w_b = $signed({6'b0, INV4PI});
            B_AS:    w_b = $signed({18'b0, w_as});
            B_CH:    w_b = 35'(r_ch);
            B_SH:    w_b = 35'(r_sh);
            B_SP:    w_b = 35'(w_sin);
            B_NCP:   w_b = 35'(ONE_Q30) - 35'(w_cos);
            default: w_b = '0;
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_rp30 = r_prod + (70'sd1 <<< 29);
    assign w_ra30 = r_acc + (70'sd1 <<< 29);
    assign w_rp16 = r_prod + 70'sd32768;

    assign w_cord_ang = i_cmd.cord_sel_phi ? r_phi : {r_pose_h, 16'h0000};

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cord_start),
        .i_angle (w_cord_ang),
        .o_busy  (w_cord_busy),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    assign w_pn  = r_prod[63:0] + {33'b0, w_h, 15'b0};
    assign w_dvd = i_cmd.div_sel_rad ? ({r_prod[46:0], 1'b0} + {31'b0, w_ad})
                                     : w_pn[63:16];
    assign w_dvs = i_cmd.div_sel_rad ? {2'b0, w_ad, 1'b0} : {4'b0, w_h};

    ddo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign w_phi_q   = w_d[16] ? 32'(-w_quot[31:0]) : w_quot[31:0];
    assign w_phi_inc = r_phi + 32'h0000_8000;
    assign w_rsat    = w_quot[47:31] != '0;
    assign w_rmag    = w_rsat ? 31'h7FFF_FFFF : w_quot[30:0];

    assign w_nx  = 36'(r_pose_x) + 36'(r_dx);
    assign w_ny  = 36'(r_pose_y) + 36'(r_dy);
    assign w_cx  = (w_nx[35:31] != 5'b00000) && (w_nx[35:31] != 5'b11111);
    assign w_cy  = (w_ny[35:31] != 5'b00000) && (w_ny[35:31] != 5'b11111);
    assign w_nxs = w_cx ? (w_nx[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_nx[31:0];
    assign w_nys = w_cy ? (w_ny[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_ny[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_track <= 16'd256;
            r_step_time  <= 16'd655;
            r_pose_x     <= '0;
            r_pose_y     <= '0;
            r_pose_h     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_TRACK:    r_half_track <= i_cfg_data[15:0];
                CFG_STEP_TIME:     r_step_time  <= i_cfg_data[15:0];
                CFG_START_X:       r_pose_x     <= i_cfg_data;
                CFG_START_Y:       r_pose_y     <= i_cfg_data;
                CFG_START_HEADING: r_pose_h     <= i_cfg_data[15:0];
                default: ;
            endcase
        end else if (i_cmd.out_load) begin
            r_pose_x <= w_nxs;
            r_pose_y <= w_nys;
            r_pose_h <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_l     <= i_left_speed;
            r_r     <= i_right_speed;
            r_head  <= r_pose_h;
            r_rclip <= 1'b0;
        end
        if (i_cmd.cap_sc) begin
            r_sh <= w_sin;
            r_ch <= w_cos;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            ACC_SUB:  r_acc <= r_acc - r_prod;
            default: ;
        endcase
        case (i_cmd.dst)
            DST_DIST: r_dist <= w_rp16[50:16];
            DST_U:    r_u    <= w_rp30[64:30];
            DST_W:    r_w    <= w_rp30[64:30];
            DST_DXP:  r_dx   <= w_rp30[64:30];
            DST_DYP:  r_dy   <= w_rp30[64:30];
            DST_DXA:  r_dx   <= w_ra30[64:30];
            DST_DYA:  r_dy   <= w_ra30[64:30];
            default: ;
        endcase
        if (i_cmd.cap_phi) begin
            r_phi <= w_phi_q;
        end
        if (i_cmd.cap_rad) begin
            r_rad   <= (w_s[16] != w_d[16]) ? -$signed({1'b0, w_rmag})
                                            : $signed({1'b0, w_rmag});
            r_rclip <= w_rsat;
        end
        if (i_cmd.head_upd) begin
            r_head <= r_pose_h + w_phi_inc[31:16];
        end
        if (i_cmd.out_load) begin
            o_new_x         <= w_nxs;
            o_new_y         <= w_nys;
            o_new_heading   <= r_head;
            o_went_straight <= (w_d == 17'sd0);
            o_clipped       <= r_rclip | w_cx | w_cy;
        end
    end

    assign o_sts.straight  = (w_d == 17'sd0);
    assign o_sts.cord_busy = w_cord_busy;
    assign o_sts.div_busy  = w_div_busy;

endmodule
`default_nettype wire

### hdl/ddo_ctrl.sv
// Odometry sequencer: one-hot state machine that steps the datapath through one update.
// Depends on ddo_pkg and the assertion macro header.
`default_nettype none
`include "differential_drive_odometry_macros.svh"
module ddo_ctrl import ddo_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    typedef enum logic [22:0] {
        S_IDLE  = 23'd1 << 0,
        S_START = 23'd1 << 1,
        S_HEAD  = 23'd1 << 2,
        S_NUM   = 23'd1 << 3,
        S_DIVA  = 23'd1 << 4,
        S_DIVAW = 23'd1 << 5,
        S_DIVB  = 23'd1 << 6,
        S_DIVBW = 23'd1 << 7,
        S_ROT   = 23'd1 << 8,
        S_ROTW  = 23'd1 << 9,
        S_M1    = 23'd1 << 10,
        S_M2    = 23'd1 << 11,
        S_M3    = 23'd1 << 12,
        S_M4    = 23'd1 << 13,
        S_M5    = 23'd1 << 14,
        S_M6    = 23'd1 << 15,
        S_M7    = 23'd1 << 16,
        S_M8    = 23'd1 << 17,
        S_M9    = 23'd1 << 18,
        S_SA    = 23'd1 << 19,
        S_SB    = 23'd1 << 20,
        S_SC    = 23'd1 << 21,
        S_DONE  = 23'd1 << 22
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{asel: A_L, bsel: B_ST, acc_op: ACC_HOLD, dst: DST_NONE, default: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.cord_start = 1'b1;
                o_cmd.mul_en     = 1'b1;
                o_cmd.asel       = i_sts.straight ? A_L : A_AD;
                o_cmd.bsel       = B_ST;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                if (!i_sts.cord_busy) begin
                    o_cmd.cap_sc = 1'b1;
                    o_cmd.dst    = DST_DIST;
                    n_state = i_sts.straight ? S_SA : S_NUM;
                end
            end
            S_NUM: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.asel   = A_PROD;
                o_cmd.bsel   = B_INV;
                n_state = S_DIVA;
            end
            S_DIVA: begin
                o_cmd.div_start = 1'b1;
                o_cmd.mul_en    = 1'b1;
                o_cmd.asel      = A_H;
                o_cmd.bsel      = B_AS;
                n_state = S_DIVAW;
            end
            S_DIVAW: begin
                if (!i_sts.div_busy) begin
                    o_cmd.cap_phi = 1'b1;
                    n_state = S_DIVB;
                end
            end
            S_DIVB: begin
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_rad = 1'b1;
                n_state = S_DIVBW;
            end
            S_DIVBW: begin
                if (!i_sts.div_busy) begin
                    o_cmd.cap_rad = 1'b1;
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                o_cmd.cord_start   = 1'b1;
                o_cmd.cord_sel_phi = 1'b1;
                o_cmd.head_upd     = 1'b1;
                n_state = S_ROTW;
            end
            S_ROTW: begin
                if (!i_sts.cord_busy) begin
                    n_state = S_M1;
                end
            end
            S_M1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.asel   = A_RAD;
                o_cmd.bsel   = B_SP;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd.dst    = DST_U;
                o_cmd.mul_en = 1'b1;
                o_cmd.asel   = A_RAD;
                o_cmd.bsel   = B_NCP;
                n_state = S_M3;
            end
            S_M3: begin
                o_cmd.dst = DST_W;
                n_state = S_M4;
            end
            S_M4: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.asel   = A_U;
                o_cmd.bsel   = B_CH;
                n_state = S_M5;
            end
            S_M5: begin
                o_cmd.acc_op = ACC_LOAD;
                o_cmd.mul_en = 1'b1;
                o_cmd.asel   = A_W;
                o_cmd.bsel   = B_SH;
                n_state = S_M6;
            end
            S_M6: begin
                o_cmd.acc_op = ACC_SUB;
                o_cmd.mul_en = 1'b1;
                o_cmd.asel   = A_U;
                o_cmd.bsel   = B_SH;
                n_state = S_M7;
            end
            S_M7: begin
                o_cmd.dst    = DST_DXA;
                o_cmd.acc_op = ACC_LOAD;
                o_cmd.mul_en = 1'b1;
                o_cmd.asel   = A_W;
                o_cmd.bsel   = B_CH;
                n_state = S_M8;
            end
            S_M8: begin
                o_cmd.acc_op = ACC_ADD;
                n_state = S_M9;
            end
            S_M9: begin
                o_cmd.dst = DST_DYA;
                n_state = S_DONE;
            end
            S_SA: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.asel   = A_DIST;
                o_cmd.bsel   = B_CH;
                n_state = S_SB;
            end
            S_SB: begin
                o_cmd.dst    = DST_DXP;
                o_cmd.mul_en = 1'b1;
                o_cmd.asel   = A_DIST;
                o_cmd.bsel   = B_SH;
                n_state = S_SC;
            end
            S_SC: begin
                o_cmd.dst = DST_DYP;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.out_load | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `DDO_ASSERT_IMP(a_cord_start_free, o_cmd.cord_start, !i_sts.cord_busy, "CORDIC restarted while busy")
    `DDO_ASSERT_IMP(a_div_start_free, o_cmd.div_start, !i_sts.div_busy, "divider restarted while busy")
    `DDO_ASSERT_IMP(a_out_load_free, o_cmd.out_load, !r_out_valid || !i_out_stall, "result beat overwritten")
    `DDO_ASSERT(a_out_rise, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result beat outside done")

endmodule
`default_nettype wire

### hdl/differential_drive_odometry.sv
// Throughput: one item at a time; the next beat is taken the cycle after the result is staged.
// Straight time is set by one 24-step CORDIC pass; turning adds a second pass and two 48-step
// divides, all sequential.
// Reset (synchronous, active low) clears the pose, loads default track and step time.
// A pending result beat does not block acceptance of the next input beat.
`default_nettype none
module differential_drive_odometry import ddo_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_left_speed,
    input  wire logic signed [15:0] i_right_speed,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_new_x,
    output logic signed [31:0]      o_new_y,
    output logic [15:0]             o_new_heading,
    output logic                    o_went_straight,
    output logic                    o_clipped
);

    t_cmd w_cmd;
    t_sts w_sts;

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    ddo_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_left_speed    (i_left_speed),
        .i_right_speed   (i_right_speed),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_new_x         (o_new_x),
        .o_new_y         (o_new_y),
        .o_new_heading   (o_new_heading),
        .o_went_straight (o_went_straight),
        .o_clipped       (o_clipped)
    );

endmodule
`default_nettype wire
